// ----- src/sqps_pkg.sv -----
// ============================================================================
// sqps_pkg - shared types and constants for the stack/queue pass sorter
// controller states, controller commands and datapath status
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package sqps_pkg;

  localparam int unsigned DEPTH_DEF     = 32;
  localparam int unsigned KEY_WIDTH_DEF = 32;
  localparam int unsigned KEY_IO_W      = 32;
  localparam int unsigned PASS_W        = 8;
  localparam int unsigned IN_DATA_W     = 32;
  localparam int unsigned OUT_DATA_W    = 48;

  // another pass may start only while the count is below this value
  localparam logic [PASS_W-1:0] PASS_AGAIN_MAX = 8'd254;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_INIT,
    ST_RD_HEAD,
    ST_RD_NEXT,
    ST_MOVE,
    ST_WAIT_NEXT,
    ST_WAIT_TOP,
    ST_DRAIN,
    ST_DRAIN_WAIT,
    ST_PASS_END,
    ST_EMIT_RD,
    ST_EMIT_CAP,
    ST_EMIT_WAIT
  } sqps_state_t;

  typedef struct packed {
    logic load;       // take input items
    logic init;       // start of a pass
    logic cap_head;   // capture first head
    logic cap_next;   // capture item after the head
    logic move;       // one move of the pass
    logic cap_top;    // capture new stack top
    logic drain;      // pop leftover stack into output list
    logic pass_end;   // swap banks, count pass
    logic emit_cap;   // load output register
    logic emit_wait;  // hold output until taken
  } sqps_cmd_t;

  typedef struct packed {
    logic load_last;   // item marked last accepted
    logic q_done;      // queue empty
    logic pop;         // move pops the stack
    logic lone;        // single item left in queue
    logic next_more;   // an item exists after the new head
    logic stack_multi; // stack holds two or more
    logic s_empty;     // stack empty
    logic again;       // another pass needed
    logic out_hs;      // result item taken
    logic emit_last;   // current result is the final one
  } sqps_stat_t;

endpackage

`default_nettype wire

// ----- src/sqps_ram.sv -----
// ============================================================================
// sqps_ram - generic single write, single read ram
// one write port, one read port with registered read data
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module sqps_ram
  import sqps_pkg::*;
#(
  parameter int unsigned WIDTH = KEY_WIDTH_DEF,
  parameter int unsigned DEPTH = DEPTH_DEF,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

// ----- src/sqps_ctrl.sv -----
// ============================================================================
// sqps_ctrl - sequencer of the pass sorter
// steps load, pass moves, stack drain and emission from datapath status
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module sqps_ctrl
  import sqps_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire sqps_stat_t stat_i,
  output sqps_cmd_t       cmd_o
);

  sqps_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD: begin
        if (stat_i.load_last) state_nxt = ST_INIT;
      end
      ST_INIT:      state_nxt = ST_RD_HEAD;
      ST_RD_HEAD:   state_nxt = ST_RD_NEXT;
      ST_RD_NEXT:   state_nxt = ST_MOVE;
      ST_MOVE: begin
        if (stat_i.q_done) begin
          state_nxt = ST_DRAIN;
        end else if (stat_i.pop) begin
          state_nxt = stat_i.stack_multi ? ST_WAIT_TOP : ST_MOVE;
        end else if (stat_i.lone) begin
          state_nxt = ST_DRAIN;
        end else begin
          state_nxt = stat_i.next_more ? ST_WAIT_NEXT : ST_MOVE;
        end
      end
      ST_WAIT_NEXT: state_nxt = ST_MOVE;
      ST_WAIT_TOP:  state_nxt = ST_MOVE;
      ST_DRAIN: begin
        if (stat_i.s_empty) begin
          state_nxt = ST_PASS_END;
        end else if (stat_i.stack_multi) begin
          state_nxt = ST_DRAIN_WAIT;
        end
      end
      ST_DRAIN_WAIT: state_nxt = ST_DRAIN;
      ST_PASS_END:   state_nxt = stat_i.again ? ST_INIT : ST_EMIT_RD;
      ST_EMIT_RD:    state_nxt = ST_EMIT_CAP;
      ST_EMIT_CAP:   state_nxt = ST_EMIT_WAIT;
      ST_EMIT_WAIT: begin
        if (stat_i.out_hs) state_nxt = stat_i.emit_last ? ST_LOAD : ST_EMIT_RD;
      end
      default:       state_nxt = ST_LOAD;
    endcase
  end

  // commands
  always_comb begin
    cmd_o = '0;
    unique case (state_r)
      ST_LOAD:       cmd_o.load      = 1'b1;
      ST_INIT:       cmd_o.init      = 1'b1;
      ST_RD_HEAD:    cmd_o.cap_head  = 1'b1;
      ST_RD_NEXT:    cmd_o.cap_next  = 1'b1;
      ST_MOVE:       cmd_o.move      = 1'b1;
      ST_WAIT_NEXT:  cmd_o.cap_next  = 1'b1;
      ST_WAIT_TOP:   cmd_o.cap_top   = 1'b1;
      ST_DRAIN:      cmd_o.drain     = 1'b1;
      ST_DRAIN_WAIT: cmd_o.cap_top   = 1'b1;
      ST_PASS_END:   cmd_o.pass_end  = 1'b1;
      ST_EMIT_RD:    cmd_o           = '0;
      ST_EMIT_CAP:   cmd_o.emit_cap  = 1'b1;
      ST_EMIT_WAIT:  cmd_o.emit_wait = 1'b1;
      default:       cmd_o           = '0;
    endcase
  end

endmodule

`default_nettype wire

// ----- src/sqps_dp.sv -----
// ============================================================================
// sqps_dp - datapath of the pass sorter
// list banks, stack ram, pass counters, move decision and result register
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module sqps_dp
  import sqps_pkg::*;
#(
  parameter int unsigned DEPTH     = DEPTH_DEF,
  parameter int unsigned KEY_WIDTH = KEY_WIDTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire sqps_cmd_t            cmd_i,
  output sqps_stat_t                stat_o,
  input  wire logic                 in_tvalid,
  input  wire logic [IN_DATA_W-1:0] in_tdata,
  input  wire logic                 in_tlast,
  input  wire logic                 out_tready,
  output logic                      out_valid_o,
  output logic                      out_last_o,
  output logic [KEY_IO_W-1:0]       out_key_o,
  output logic [PASS_W-1:0]         out_passes_o,
  output logic                      out_ovf_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned IW = (KEY_WIDTH < KEY_IO_W) ? KEY_WIDTH : KEY_IO_W;
  localparam int unsigned KW = KEY_WIDTH;

  logic [CW-1:0]        count_r, qh_r, on_r, sd_r, ei_r;
  logic                 ovf_r, bank_r, pushed_r;
  logic [PASS_W-1:0]    passes_r;
  logic signed [KW-1:0] last_r, head_r, next_r, top_r, out_key_r;
  logic                 out_valid_r, out_last_r;

  logic signed [KW-1:0] key_in;
  logic                 in_hs, full, stack_ne, out_ne;
  logic                 pop_c, lone_c, push_c, move_act;
  logic [CW:0]          qh_p1, qh_p2, ei_p1;
  logic [CW:0]          q_rd_idx;
  logic [CW-1:0]        sd_m2;

  logic                 q_we;
  logic [AW:0]          q_waddr, q_raddr;
  logic [KW-1:0]        q_wdata, q_rdata;
  logic                 s_we;
  logic [KW-1:0]        s_rdata;

  assign key_in   = KW'($signed(in_tdata[IW-1:0]));
  assign in_hs    = cmd_i.load & in_tvalid;
  assign full     = (count_r == CW'(DEPTH));
  assign stack_ne = (sd_r != '0);
  assign out_ne   = (on_r != '0);
  assign qh_p1    = {1'b0, qh_r} + (CW+1)'(1);
  assign qh_p2    = {1'b0, qh_r} + (CW+1)'(2);
  assign ei_p1    = {1'b0, ei_r} + (CW+1)'(1);
  assign sd_m2    = sd_r - CW'(2);

  // move decision for the current head, next item and stack top
  assign pop_c    = stack_ne && out_ne &&
                    (((head_r < top_r) && (top_r < last_r)) || (top_r == head_r));
  assign lone_c   = !pop_c && (qh_p1 == {1'b0, count_r});
  assign push_c   = (head_r < next_r);
  assign move_act = cmd_i.move && (qh_r != count_r);

  always_comb begin
    stat_o             = '0;
    stat_o.load_last   = in_hs & in_tlast;
    stat_o.q_done      = (qh_r == count_r);
    stat_o.pop         = pop_c;
    stat_o.lone        = lone_c;
    stat_o.next_more   = (qh_p2 < {1'b0, count_r});
    stat_o.stack_multi = (sd_r >= CW'(2));
    stat_o.s_empty     = !stack_ne;
    stat_o.again       = pushed_r && (passes_r < PASS_AGAIN_MAX);
    stat_o.out_hs      = out_valid_r & out_tready;
    stat_o.emit_last   = (ei_p1 == {1'b0, count_r});
  end

  // list ram port selection: the list lives in bank_r, the output list in the other
  always_comb begin
    q_we    = 1'b0;
    q_waddr = {bank_r, count_r[AW-1:0]};
    q_wdata = key_in;
    if (in_hs && !full) begin
      q_we = 1'b1;
    end else if (move_act && (pop_c || lone_c || !push_c)) begin
      q_we    = 1'b1;
      q_waddr = {~bank_r, on_r[AW-1:0]};
      q_wdata = pop_c ? top_r : head_r;
    end else if (cmd_i.drain && stack_ne) begin
      q_we    = 1'b1;
      q_waddr = {~bank_r, on_r[AW-1:0]};
      q_wdata = top_r;
    end
  end

  always_comb begin
    if (cmd_i.init) begin
      q_rd_idx = '0;
    end else if (cmd_i.cap_head) begin
      q_rd_idx = (CW+1)'(1);
    end else if (cmd_i.move) begin
      q_rd_idx = qh_p2;
    end else begin
      q_rd_idx = {1'b0, ei_r};
    end
  end

  assign q_raddr = {bank_r, q_rd_idx[AW-1:0]};
  assign s_we    = move_act && !pop_c && !lone_c && push_c;

  // each bank spans a full power-of-two address range
  sqps_ram #(
    .WIDTH (KW),
    .DEPTH (2 * (2 ** AW))
  ) u_list_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (q_wdata),
    .raddr (q_raddr),
    .rdata (q_rdata)
  );

  sqps_ram #(
    .WIDTH (KW),
    .DEPTH (DEPTH)
  ) u_stack_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (sd_r[AW-1:0]),
    .wdata (head_r),
    .raddr (sd_m2[AW-1:0]),
    .rdata (s_rdata)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      ovf_r       <= 1'b0;
      bank_r      <= 1'b0;
      qh_r        <= '0;
      on_r        <= '0;
      sd_r        <= '0;
      pushed_r    <= 1'b0;
      passes_r    <= '0;
      ei_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_hs) begin
        if (full) begin
          ovf_r <= 1'b1;
        end else begin
          count_r <= count_r + CW'(1);
        end
      end
      if (cmd_i.init) begin
        qh_r     <= '0;
        on_r     <= '0;
        sd_r     <= '0;
        pushed_r <= 1'b0;
      end
      if (move_act) begin
        if (pop_c) begin
          on_r <= on_r + CW'(1);
          sd_r <= sd_r - CW'(1);
        end else begin
          qh_r <= qh_r + CW'(1);
          if (!lone_c && push_c) begin
            sd_r     <= sd_r + CW'(1);
            pushed_r <= 1'b1;
          end else begin
            on_r <= on_r + CW'(1);
          end
        end
      end
      if (cmd_i.drain && stack_ne) begin
        on_r <= on_r + CW'(1);
        sd_r <= sd_r - CW'(1);
      end
      if (cmd_i.pass_end) begin
        bank_r   <= ~bank_r;
        passes_r <= passes_r + PASS_W'(1);
      end
      if (cmd_i.emit_cap) begin
        out_valid_r <= 1'b1;
      end
      if (cmd_i.emit_wait && out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
        if (ei_p1 == {1'b0, count_r}) begin
          count_r  <= '0;
          ovf_r    <= 1'b0;
          ei_r     <= '0;
          passes_r <= '0;
        end else begin
          ei_r <= ei_r + CW'(1);
        end
      end
    end
  end

  // key registers
  always_ff @(posedge clk) begin
    if (cmd_i.init) begin
      last_r <= '0;
    end else if (move_act && !lone_c) begin
      last_r <= pop_c ? top_r : head_r;
    end
    if (cmd_i.cap_head) begin
      head_r <= q_rdata;
    end else if (move_act && !pop_c && !lone_c) begin
      head_r <= next_r;
    end
    if (cmd_i.cap_next) begin
      next_r <= q_rdata;
    end
    if (cmd_i.cap_top) begin
      top_r <= s_rdata;
    end else if (s_we) begin
      top_r <= head_r;
    end
    if (cmd_i.emit_cap) begin
      out_key_r  <= q_rdata;
      out_last_r <= (ei_p1 == {1'b0, count_r});
    end
  end

  assign out_valid_o  = out_valid_r;
  assign out_last_o   = out_last_r;
  assign out_key_o    = KEY_IO_W'(out_key_r);
  assign out_passes_o = passes_r;
  assign out_ovf_o    = ovf_r;

`ifndef NO_ASSERTIONS
  // every key that left the queue sits in the output list or on the stack
  a_conserve: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, on_r} + {1'b0, sd_r}) == {1'b0, qh_r})
    else $error("queue, stack and output counts disagree");

  a_stack_cap: assert property (@(posedge clk) disable iff (!rst_n)
    sd_r <= CW'(DEPTH))
    else $error("stack depth beyond capacity");

  a_no_load_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !cmd_i.load)
    else $error("input taken while a result is pending");

  a_pass_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (passes_r != '0))
    else $error("result shown before any pass ran");

  a_emit_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd_i.emit_cap))
    else $error("result raised outside emission");
`endif

endmodule

`default_nettype wire

// ----- src/stack_queue_pass_sorter.sv -----
// ============================================================================
// stack_queue_pass_sorter - sorter moving a list through a stack in passes
// loads signed keys, runs passes until one pushes nothing or the pass limit is hit, emits the list
// ============================================================================
//
//  channel | dir | handshake         | payload
//  --------+-----+-------------------+----------------------------------------
//  in_     | in  | in_tvalid/tready  | tdata: key[31:0]; tlast: last
//  out_    | out | out_tvalid/tready | tdata: key_res, passes, overflow;
//          |     |                   | tlast: final_res
//
//  loading takes one cycle per key; a key beyond DEPTH is dropped and flagged
//  after the last key the input stalls while passes run; pass speed is limited
//  by the single read port of the list ram and the stack ram read latency
//  emission reads, captures and holds each result until it is taken, and only
//  then reads the next one, so any output stall holds emission
//  reset: synchronous, active low, clears all counters; no memory clearing
//
`timescale 1ns / 1ps
`default_nettype none

module stack_queue_pass_sorter
  import sqps_pkg::*;
#(
  parameter int unsigned DEPTH     = DEPTH_DEF,     // keys held per list
  parameter int unsigned KEY_WIDTH = KEY_WIDTH_DEF  // stored key width
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // input keys
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // [31:0] key
  input  wire logic                  in_tlast,   // last key of the list
  // sorted results
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,  // [31:0] key_res, [39:32] passes,
                                                 // [40] overflow, rest zero
  output logic                       out_tlast   // final_res
);

  sqps_cmd_t            cmd;
  sqps_stat_t           stat;
  logic                 res_valid, res_last, res_ovf;
  logic [KEY_IO_W-1:0]  res_key;
  logic [PASS_W-1:0]    res_passes;

  // sequencer
  sqps_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  // list banks, stack and result register
  sqps_dp #(
    .DEPTH     (DEPTH),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .in_tvalid    (in_tvalid),
    .in_tdata     (in_tdata),
    .in_tlast     (in_tlast),
    .out_tready   (out_tready),
    .out_valid_o  (res_valid),
    .out_last_o   (res_last),
    .out_key_o    (res_key),
    .out_passes_o (res_passes),
    .out_ovf_o    (res_ovf)
  );

  // keys are taken only while loading
  assign in_tready  = cmd.load;

  // result packing, lowest field first, padded to whole bytes
  assign out_tvalid = res_valid;
  assign out_tlast  = res_last;
  assign out_tdata  = {(OUT_DATA_W - KEY_IO_W - PASS_W - 1)'(0), res_ovf, res_passes, res_key};

endmodule

`default_nettype wire
